// ----- rtl/scaling_matrix_level_scale_macros.svh -----
// Assertion macros shared by the scaling matrix RTL.
`ifndef SCALING_MATRIX_LEVEL_SCALE_MACROS_SVH
`define SCALING_MATRIX_LEVEL_SCALE_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_IMPL(lbl, clk, rst, pre, post, msg)
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg)
`endif

`endif

// ----- rtl/sms_pkg.sv -----
// Types, constants, tables and helper functions of the scaling matrix block.
package sms_pkg;

   localparam int NUM_SMALL_LISTS = 6;
   localparam int SMALL_LEN       = 16;
   localparam int LARGE_LEN       = 64;

   localparam logic [7:0] INIT_SCALE = 8'd8;
   localparam logic [7:0] FLAT_SCALE = 8'd16;

   // action codes
   localparam logic [2:0] ACT_START    = 3'd0;
   localparam logic [2:0] ACT_DELTA    = 3'd1;
   localparam logic [2:0] ACT_FALLBACK = 3'd2;
   localparam logic [2:0] ACT_FLAT     = 3'd3;
   localparam logic [2:0] ACT_QUERY    = 3'd4;

   typedef struct packed {
      logic [2:0]        action;
      logic [2:0]        list_index;
      logic signed [7:0] delta_step;
      logic              is_pps;
      logic [5:0]        qp;
      logic [2:0]        row;
      logic [2:0]        col;
   } req_type;

   typedef struct packed {
      logic [13:0] level_scale;
      logic        list_done;
      logic        use_default;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_QWAIT,
      ST_WALK,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      WALK_FILL,
      WALK_TABLE,
      WALK_COPY,
      WALK_FLAT
   } walk_kind_type;

   typedef enum logic [1:0] {
      FB_NONE,
      FB_TABLE,
      FB_COPY
   } fb_type;

   typedef struct packed {
      logic          capture;
      logic          start_apply;
      logic          delta_apply;
      logic          walk_init;
      walk_kind_type walk_kind;
      logic          walk_step;
      logic          query_read;
      logic          query_mul;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       delta_active;
      logic       delta_zero;
      fb_type     fb_kind;
      logic       walk_last;
   } dp_status_type;

   localparam logic [7:0] DEF4_INTRA [16] = '{
      8'd6, 8'd13, 8'd13, 8'd20, 8'd20, 8'd20, 8'd28, 8'd28,
      8'd28, 8'd28, 8'd32, 8'd32, 8'd32, 8'd37, 8'd37, 8'd42};
   localparam logic [7:0] DEF4_INTER [16] = '{
      8'd10, 8'd14, 8'd14, 8'd20, 8'd20, 8'd20, 8'd24, 8'd24,
      8'd24, 8'd24, 8'd27, 8'd27, 8'd27, 8'd30, 8'd30, 8'd34};
   localparam logic [7:0] DEF8_INTRA [64] = '{
      8'd6,  8'd10, 8'd10, 8'd13, 8'd11, 8'd13, 8'd16, 8'd16,
      8'd16, 8'd16, 8'd18, 8'd18, 8'd18, 8'd18, 8'd18, 8'd23,
      8'd23, 8'd23, 8'd23, 8'd23, 8'd23, 8'd25, 8'd25, 8'd25,
      8'd25, 8'd25, 8'd25, 8'd25, 8'd27, 8'd27, 8'd27, 8'd27,
      8'd27, 8'd27, 8'd27, 8'd27, 8'd29, 8'd29, 8'd29, 8'd29,
      8'd29, 8'd29, 8'd29, 8'd31, 8'd31, 8'd31, 8'd31, 8'd31,
      8'd31, 8'd33, 8'd33, 8'd33, 8'd33, 8'd33, 8'd36, 8'd36,
      8'd36, 8'd36, 8'd38, 8'd38, 8'd38, 8'd40, 8'd40, 8'd42};
   localparam logic [7:0] DEF8_INTER [64] = '{
      8'd9,  8'd13, 8'd13, 8'd15, 8'd13, 8'd15, 8'd17, 8'd17,
      8'd17, 8'd17, 8'd19, 8'd19, 8'd19, 8'd19, 8'd19, 8'd21,
      8'd21, 8'd21, 8'd21, 8'd21, 8'd21, 8'd22, 8'd22, 8'd22,
      8'd22, 8'd22, 8'd22, 8'd22, 8'd24, 8'd24, 8'd24, 8'd24,
      8'd24, 8'd24, 8'd24, 8'd24, 8'd25, 8'd25, 8'd25, 8'd25,
      8'd25, 8'd25, 8'd25, 8'd27, 8'd27, 8'd27, 8'd27, 8'd27,
      8'd27, 8'd28, 8'd28, 8'd28, 8'd28, 8'd28, 8'd30, 8'd30,
      8'd30, 8'd30, 8'd32, 8'd32, 8'd32, 8'd33, 8'd33, 8'd35};

   localparam logic [5:0] NORM4 [6][3] = '{
      '{6'd10, 6'd13, 6'd16}, '{6'd11, 6'd14, 6'd18}, '{6'd13, 6'd16, 6'd20},
      '{6'd14, 6'd18, 6'd23}, '{6'd16, 6'd20, 6'd25}, '{6'd18, 6'd23, 6'd29}};
   localparam logic [5:0] NORM8 [6][6] = '{
      '{6'd20, 6'd18, 6'd32, 6'd19, 6'd25, 6'd24},
      '{6'd22, 6'd19, 6'd35, 6'd21, 6'd28, 6'd26},
      '{6'd26, 6'd23, 6'd42, 6'd24, 6'd33, 6'd31},
      '{6'd28, 6'd25, 6'd45, 6'd26, 6'd35, 6'd33},
      '{6'd32, 6'd28, 6'd51, 6'd30, 6'd40, 6'd38},
      '{6'd36, 6'd32, 6'd58, 6'd34, 6'd46, 6'd43}};

   localparam logic [3:0] ZZ4 [16] = '{
      4'd0, 4'd1, 4'd5, 4'd6, 4'd2, 4'd4, 4'd7, 4'd12,
      4'd3, 4'd8, 4'd11, 4'd13, 4'd9, 4'd10, 4'd14, 4'd15};
   localparam logic [5:0] ZZ8 [64] = '{
      6'd0,  6'd1,  6'd5,  6'd6,  6'd14, 6'd15, 6'd27, 6'd28,
      6'd2,  6'd4,  6'd7,  6'd13, 6'd16, 6'd26, 6'd29, 6'd42,
      6'd3,  6'd8,  6'd12, 6'd17, 6'd25, 6'd30, 6'd41, 6'd43,
      6'd9,  6'd11, 6'd18, 6'd24, 6'd31, 6'd40, 6'd44, 6'd53,
      6'd10, 6'd19, 6'd23, 6'd32, 6'd39, 6'd45, 6'd52, 6'd54,
      6'd20, 6'd22, 6'd33, 6'd38, 6'd46, 6'd51, 6'd55, 6'd60,
      6'd21, 6'd34, 6'd37, 6'd47, 6'd50, 6'd56, 6'd59, 6'd61,
      6'd35, 6'd36, 6'd48, 6'd49, 6'd57, 6'd58, 6'd62, 6'd63};

   function automatic logic is_small(input logic [2:0] idx);
      is_small = (idx < 3'(NUM_SMALL_LISTS));
   endfunction

   function automatic logic [6:0] list_len(input logic [2:0] idx);
      list_len = is_small(idx) ? 7'(SMALL_LEN) : 7'(LARGE_LEN);
   endfunction

   // 4x4 lists packed first, then the 8x8 lists
   function automatic logic [7:0] list_base(input logic [2:0] idx);
      if (is_small(idx)) begin
         list_base = {1'b0, idx, 4'b0000};
      end else begin
         list_base = 8'(NUM_SMALL_LISTS * SMALL_LEN) + {1'b0, idx[0], 6'b000000};
      end
   endfunction

   function automatic logic [7:0] default_entry(input logic [2:0] idx, input logic [5:0] pos);
      if (idx < 3'd3) begin
         default_entry = DEF4_INTRA[pos[3:0]];
      end else if (is_small(idx)) begin
         default_entry = DEF4_INTER[pos[3:0]];
      end else if (idx == 3'd6) begin
         default_entry = DEF8_INTRA[pos];
      end else begin
         default_entry = DEF8_INTER[pos];
      end
   endfunction

   // residue mod 3 from base-4 digit sum, parity picks between r and r+3
   function automatic logic [2:0] mod6(input logic [5:0] v);
      logic [3:0] s;
      logic [1:0] m;
      s = {2'b00, v[5:4]} + {2'b00, v[3:2]} + {2'b00, v[1:0]};
      case (s)
         4'd1, 4'd4, 4'd7: m = 2'd1;
         4'd2, 4'd5, 4'd8: m = 2'd2;
         default:          m = 2'd0;
      endcase
      mod6 = (m[0] == v[0]) ? {1'b0, m} : {1'b0, m} + 3'd3;
   endfunction

   function automatic logic [2:0] class8(input logic [2:0] i, input logic [2:0] j);
      if (i[1:0] == 2'd0 && j[1:0] == 2'd0) begin
         class8 = 3'd0;
      end else if (i[0] && j[0]) begin
         class8 = 3'd1;
      end else if (i[1:0] == 2'd2 && j[1:0] == 2'd2) begin
         class8 = 3'd2;
      end else if ((i[1:0] == 2'd0 && j[0]) || (i[0] && j[1:0] == 2'd0)) begin
         class8 = 3'd3;
      end else if ((i[1:0] == 2'd0 && j[1:0] == 2'd2) ||
                   (i[1:0] == 2'd2 && j[1:0] == 2'd0)) begin
         class8 = 3'd4;
      end else begin
         class8 = 3'd5;
      end
   endfunction

endpackage

// ----- rtl/sms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 224,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sms_ctrl.sv -----
// Sequencer of the scaling matrix block: clearing pass, decode, walks, response.
`include "scaling_matrix_level_scale_macros.svh"

module sms_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  sms_pkg::dp_status_type status,
   output sms_pkg::ctrl_cmd_type  cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   sms_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sms_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sms_pkg::ST_INIT: begin
            state_in = sms_pkg::ST_CLEAR;
         end
         sms_pkg::ST_CLEAR: begin
            if (status.walk_last) state_in = sms_pkg::ST_IDLE;
         end
         sms_pkg::ST_IDLE: begin
            if (start) state_in = sms_pkg::ST_EXEC;
         end
         sms_pkg::ST_EXEC: begin
            case (status.action)
               sms_pkg::ACT_DELTA: begin
                  if (status.delta_active && status.delta_zero) state_in = sms_pkg::ST_WALK;
                  else state_in = sms_pkg::ST_RESP;
               end
               sms_pkg::ACT_FALLBACK: begin
                  if (status.fb_kind != sms_pkg::FB_NONE) state_in = sms_pkg::ST_WALK;
                  else state_in = sms_pkg::ST_RESP;
               end
               sms_pkg::ACT_FLAT:  state_in = sms_pkg::ST_WALK;
               sms_pkg::ACT_QUERY: state_in = sms_pkg::ST_QWAIT;
               default:            state_in = sms_pkg::ST_RESP;
            endcase
         end
         sms_pkg::ST_QWAIT: begin
            state_in = sms_pkg::ST_RESP;
         end
         sms_pkg::ST_WALK: begin
            if (status.walk_last) state_in = sms_pkg::ST_RESP;
         end
         sms_pkg::ST_RESP: begin
            state_in = sms_pkg::ST_IDLE;
         end
         default: begin
            state_in = sms_pkg::ST_INIT;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.walk_kind = sms_pkg::WALK_FILL;
      rsp_valid     = 1'b0;
      busy          = 1'b1;
      case (state_ff)
         sms_pkg::ST_INIT: begin
            cmd.walk_init = 1'b1;
            cmd.walk_kind = sms_pkg::WALK_FLAT;
         end
         sms_pkg::ST_CLEAR: begin
            cmd.walk_step = 1'b1;
         end
         sms_pkg::ST_IDLE: begin
            busy        = 1'b0;
            cmd.capture = start;
         end
         sms_pkg::ST_EXEC: begin
            case (status.action)
               sms_pkg::ACT_START: begin
                  cmd.start_apply = 1'b1;
               end
               sms_pkg::ACT_DELTA: begin
                  cmd.delta_apply = status.delta_active;
                  cmd.walk_init   = status.delta_active && status.delta_zero;
                  cmd.walk_kind   = sms_pkg::WALK_FILL;
               end
               sms_pkg::ACT_FALLBACK: begin
                  cmd.walk_init = (status.fb_kind != sms_pkg::FB_NONE);
                  cmd.walk_kind = (status.fb_kind == sms_pkg::FB_COPY) ?
                                  sms_pkg::WALK_COPY : sms_pkg::WALK_TABLE;
               end
               sms_pkg::ACT_FLAT: begin
                  cmd.walk_init = 1'b1;
                  cmd.walk_kind = sms_pkg::WALK_FLAT;
               end
               sms_pkg::ACT_QUERY: begin
                  cmd.query_read = 1'b1;
               end
               default: begin
                  cmd.capture = 1'b0;
               end
            endcase
         end
         sms_pkg::ST_QWAIT: begin
            cmd.query_mul = 1'b1;
         end
         sms_pkg::ST_WALK: begin
            cmd.walk_step = 1'b1;
         end
         sms_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   `ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid && !busy, "response longer than one cycle")
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid, "accepted transaction not held busy")
   `ASSERT_NEXT(a_walk_resp, clock, reset, state_ff == sms_pkg::ST_WALK && status.walk_last, rsp_valid, "walk end without response")

endmodule

// ----- rtl/sms_datapath.sv -----
// Datapath: list state, walk counter, RAM port muxing and level-scale multiply.
`include "scaling_matrix_level_scale_macros.svh"

module sms_datapath #(
   parameter int DEPTH = 224,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sms_pkg::req_type       req_data,
   input  sms_pkg::ctrl_cmd_type  cmd,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic                   csr_data,
   output sms_pkg::dp_status_type status,
   output sms_pkg::rsp_type       rsp_data
);

   sms_pkg::req_type       req_ff, req_in;
   logic                   seq_ff, seq_in;
   logic [7:0]             marks_ff, marks_in;
   logic [7:0]             last_ff, last_in;
   logic [7:0]             next_ff, next_in;
   logic [6:0]             fill_ff, fill_in;
   logic [2:0]             open_ff, open_in;
   logic [AW-1:0]          cnt_ff, cnt_in;
   logic [AW-1:0]          end_ff, end_in;
   logic [AW-1:0]          wr_base_ff, wr_base_in;
   logic [AW-1:0]          rd_base_ff, rd_base_in;
   sms_pkg::walk_kind_type kind_ff, kind_in;
   logic [13:0]            prod_ff, prod_in;

   logic [7:0]    new_scale;
   logic [6:0]    open_len;
   logic [AW-1:0] open_base;
   logic [AW-1:0] req_base;
   logic          delta_active;
   logic          delta_zero;
   logic          walk_last;
   logic          fb_dflt;
   logic          fb_rule_b;
   logic          fb_top;
   sms_pkg::fb_type fb_kind;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic [5:0]    zz_off;
   logic [2:0]    q_mod;
   logic [5:0]    norm;

   assign new_scale    = last_ff + 8'(req_ff.delta_step);
   assign open_len     = sms_pkg::list_len(open_ff);
   assign open_base    = AW'(sms_pkg::list_base(open_ff));
   assign req_base     = AW'(sms_pkg::list_base(req_ff.list_index));
   assign delta_active = (next_ff != 8'd0) && (fill_ff < open_len);
   assign delta_zero   = (new_scale == 8'd0);
   assign walk_last    = (cnt_ff == end_ff);

   // lists 0, 3, 6, 7 head their group and never inherit
   assign fb_dflt   = marks_ff[req_ff.list_index];
   assign fb_rule_b = req_ff.is_pps && seq_ff;
   assign fb_top    = (req_ff.list_index == 3'd0) || (req_ff.list_index == 3'd3) ||
                      (req_ff.list_index == 3'd6) || (req_ff.list_index == 3'd7);

   always_comb begin
      if (fb_top) begin
         fb_kind = (fb_dflt || !fb_rule_b) ? sms_pkg::FB_TABLE : sms_pkg::FB_NONE;
      end else begin
         fb_kind = fb_dflt ? sms_pkg::FB_TABLE : sms_pkg::FB_COPY;
      end
   end

   assign status.action       = req_ff.action;
   assign status.delta_active = delta_active;
   assign status.delta_zero   = delta_zero;
   assign status.fb_kind      = fb_kind;
   assign status.walk_last    = walk_last;

   // architectural list state and configuration
   always_comb begin
      req_in   = req_ff;
      seq_in   = seq_ff;
      marks_in = marks_ff;
      last_in  = last_ff;
      next_in  = next_ff;
      fill_in  = fill_ff;
      open_in  = open_ff;
      if (cmd.capture) req_in = req_data;
      if (csr_valid && csr_ready) seq_in = csr_data;
      if (cmd.start_apply) begin
         open_in  = req_ff.list_index;
         last_in  = sms_pkg::INIT_SCALE;
         next_in  = sms_pkg::INIT_SCALE;
         fill_in  = 7'd0;
         marks_in[req_ff.list_index] = 1'b0;
      end
      if (cmd.delta_apply) begin
         next_in = new_scale;
         marks_in[open_ff] = (fill_ff == 7'd0) && delta_zero;
         if (delta_zero) begin
            // rest of the list is written by the fill walk
            fill_in = open_len;
         end else begin
            last_in = new_scale;
            fill_in = fill_ff + 7'd1;
         end
      end
   end

   // walk counter and bounds
   always_comb begin
      cnt_in     = cnt_ff;
      end_in     = end_ff;
      wr_base_in = wr_base_ff;
      rd_base_in = rd_base_ff;
      kind_in    = kind_ff;
      if (cmd.walk_init) begin
         kind_in    = cmd.walk_kind;
         cnt_in     = '0;
         rd_base_in = req_base - AW'(sms_pkg::SMALL_LEN);
         case (cmd.walk_kind)
            sms_pkg::WALK_FILL: begin
               cnt_in     = AW'(fill_ff);
               end_in     = AW'(open_len - 7'd1);
               wr_base_in = open_base;
            end
            sms_pkg::WALK_TABLE: begin
               end_in     = AW'(sms_pkg::list_len(req_ff.list_index) - 7'd1);
               wr_base_in = req_base;
            end
            sms_pkg::WALK_COPY: begin
               // one extra step: each write trails its registered read
               end_in     = AW'(sms_pkg::SMALL_LEN);
               wr_base_in = req_base - AW'(1);
            end
            default: begin
               end_in     = AW'(DEPTH - 1);
               wr_base_in = '0;
            end
         endcase
      end else if (cmd.walk_step) begin
         cnt_in = cnt_ff + AW'(1);
      end
   end

   // RAM ports
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wr_base_ff + cnt_ff;
      wr_data = sms_pkg::FLAT_SCALE;
      if (cmd.walk_step) begin
         case (kind_ff)
            sms_pkg::WALK_FILL:  wr_data = last_ff;
            sms_pkg::WALK_TABLE: wr_data = sms_pkg::default_entry(req_ff.list_index, cnt_ff[5:0]);
            sms_pkg::WALK_COPY:  wr_data = rd_data;
            default:             wr_data = sms_pkg::FLAT_SCALE;
         endcase
         wr_en = (kind_ff != sms_pkg::WALK_COPY) || (cnt_ff != '0);
      end else if (cmd.delta_apply && !delta_zero) begin
         wr_en   = 1'b1;
         wr_addr = open_base + AW'(fill_ff);
         wr_data = new_scale;
      end
   end

   always_comb begin
      if (sms_pkg::is_small(req_ff.list_index)) begin
         zz_off = {2'b00, sms_pkg::ZZ4[{req_ff.row[1:0], req_ff.col[1:0]}]};
      end else begin
         zz_off = sms_pkg::ZZ8[{req_ff.row, req_ff.col}];
      end
      rd_en   = 1'b0;
      rd_addr = req_base + AW'(zz_off);
      if (cmd.query_read) begin
         rd_en = 1'b1;
      end else if (cmd.walk_step && kind_ff == sms_pkg::WALK_COPY && !walk_last) begin
         rd_en   = 1'b1;
         rd_addr = rd_base_ff + cnt_ff;
      end
   end

   sms_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // level scale: normAdjust by position class times the stored weight
   always_comb begin
      q_mod = sms_pkg::mod6(req_ff.qp);
      if (sms_pkg::is_small(req_ff.list_index)) begin
         norm = sms_pkg::NORM4[q_mod][{1'b0, req_ff.row[0]} + {1'b0, req_ff.col[0]}];
      end else begin
         norm = sms_pkg::NORM8[q_mod][sms_pkg::class8(req_ff.row, req_ff.col)];
      end
      prod_in = prod_ff;
      if (cmd.query_mul) prod_in = 14'(norm) * 14'(rd_data);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff   <= 1'b0;
         marks_ff <= '0;
         last_ff  <= sms_pkg::INIT_SCALE;
         next_ff  <= sms_pkg::INIT_SCALE;
         fill_ff  <= 7'd0;
         open_ff  <= 3'd0;
      end else begin
         seq_ff   <= seq_in;
         marks_ff <= marks_in;
         last_ff  <= last_in;
         next_ff  <= next_in;
         fill_ff  <= fill_in;
         open_ff  <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      cnt_ff     <= cnt_in;
      end_ff     <= end_in;
      wr_base_ff <= wr_base_in;
      rd_base_ff <= rd_base_in;
      kind_ff    <= kind_in;
      prod_ff    <= prod_in;
   end

   assign rsp_data.level_scale = (req_ff.action == sms_pkg::ACT_QUERY) ? prod_ff : 14'd0;
   assign rsp_data.list_done   = (req_ff.action == sms_pkg::ACT_DELTA) &&
                                 ((next_ff == 8'd0) || (fill_ff >= open_len));
   assign rsp_data.use_default = (req_ff.action == sms_pkg::ACT_DELTA) && marks_ff[open_ff];

   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= sms_pkg::list_len(open_ff), "fill position beyond list")
   `ASSERT_IMPL(a_mark_closed, clock, reset, marks_ff[open_ff], next_ff == 8'd0, "use-default mark on a list still open")
   `ASSERT_NEXT(a_delta_step, clock, reset, cmd.delta_apply && !delta_zero, fill_ff == $past(fill_ff) + 7'd1, "delta write did not advance fill")

endmodule

// ----- rtl/scaling_matrix_level_scale.sv -----
// Top level of the H.264 scaling list store and dequant level-scale unit.
//
// Input: a transaction is taken when start is high and busy is low; req_data
// carries the action and its operands. Every transaction gives exactly one
// result: rsp_valid is high for one cycle with rsp_data, and the receiver
// must take it then (it cannot stall the block).
// Configuration: csr_data is written to seq_lists_present when csr_valid and
// csr_ready are high; csr_ready is always high. Write only while idle.
// Walks (busy stays high while one runs; a query instead does a registered
// RAM read, then the multiply; start, ignored delta, no-op fallback, a delta
// storing one scale and unused codes do no walk):
//   delta ending the list: entries left to fill (up to 64)
//   fallback to default table: list length (16 or 64)
//   fallback copy of a 4x4 list: 16 entries, read and write overlapping
//   flat fill: store depth (224 at the default parameter)
// The list RAM has one write and one registered read port; every multi-entry
// action walks it one entry per cycle.
// Reset: synchronous; afterwards the block runs a clearing pass that writes 16
// to every entry, one per cycle, with busy high.
module scaling_matrix_level_scale #(
   parameter int NUM_LARGE_LISTS = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  sms_pkg::req_type req_data,
   output logic             rsp_valid,
   output sms_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_data
);

   localparam int DEPTH = sms_pkg::NUM_SMALL_LISTS * sms_pkg::SMALL_LEN +
                          NUM_LARGE_LISTS * sms_pkg::LARGE_LEN;

   sms_pkg::ctrl_cmd_type  cmd;
   sms_pkg::dp_status_type status;

   assign csr_ready = 1'b1;

   sms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   sms_datapath #(
      .DEPTH(DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
